// ===== rtl/hglc_pkg.sv =====
// Package for the HTTP GET request-line checker: phase and verdict codes,
// literal text lookups and the sizing constants.
// No dependencies.
`timescale 1ns / 1ps

package hglc_pkg;

  // Bytes one request may take before it is closed out.
  localparam int unsigned MAX_REQUEST = 1024;
  localparam int unsigned BYTE_CNT_W  = $clog2(MAX_REQUEST + 1);

  localparam int unsigned PATH_LEN_W = 10;
  localparam logic [PATH_LEN_W-1:0] PATH_LEN_MAX = '1;

  localparam int unsigned DEPTH_W = 12;
  localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;

  typedef enum logic [4:0] {
    PH_METHOD   = 5'b00001,
    PH_PRESLASH = 5'b00010,
    PH_PATH     = 5'b00100,
    PH_PREVER   = 5'b01000,
    PH_VERSION  = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    VERDICT_ACCEPTED  = 3'd0,
    VERDICT_BAD_METHOD = 3'd1,
    VERDICT_NO_SLASH  = 3'd2,
    VERDICT_TRAILING  = 3'd3,
    VERDICT_ESCAPES   = 3'd4,
    VERDICT_BAD_VER   = 3'd5
  } verdict_e;

  typedef enum logic {
    KIND_PATH    = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  // "GET "
  function automatic logic [7:0] method_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h54;
      default: c = CHAR_SPACE;
    endcase
    return c;
  endfunction

  // "HTTP/1.1"
  function automatic logic [7:0] version_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      3'd4:    c = CHAR_SLASH;
      3'd5:    c = 8'h31;
      3'd6:    c = CHAR_DOT;
      default: c = 8'h31;
    endcase
    return c;
  endfunction

  // "../"
  function automatic logic [7:0] dotdot_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CHAR_DOT;
      2'd1:    c = CHAR_DOT;
      default: c = CHAR_SLASH;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/hglc_req_if.sv =====
// Request byte channel: valid/ready handshake with one request byte per beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface hglc_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;

  modport source (output valid, output data_byte, output first, input ready);
  modport sink   (input valid, input data_byte, input first, output ready);
endinterface

// ===== rtl/hglc_res_if.sv =====
// Result channel: valid/ready handshake carrying a path byte or a verdict.
// Depends on hglc_pkg.
`timescale 1ns / 1ps

interface hglc_res_if
  import hglc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [7:0]            path_byte;
  logic [2:0]            verdict;
  logic [PATH_LEN_W-1:0] path_length;

  modport source (output valid, output kind, output path_byte, output verdict,
                  output path_length, input ready);
  modport sink   (input valid, input kind, input path_byte, input verdict,
                  input path_length, output ready);
endinterface

// ===== rtl/http_get_request_line_check_top.sv =====
// Channel   Dir  Payload                                   Beat
// req_i     in   data_byte[7:0], first                     one request byte
// res_o     out  kind, path_byte[7:0], verdict[2:0],       path byte or verdict
//                path_length[9:0]
//
// One byte is taken per cycle while req_i.ready is high; its result reaches
// the result register on the next edge.
// The result register is the only buffer: req_i.ready drops only while a
// result sits there and res_o.ready is low. Reset leaves the parser at the
// start of a request with no result pending.
// Depends on hglc_pkg, hglc_req_if and hglc_res_if.
`timescale 1ns / 1ps

module http_get_request_line_check_top
  import hglc_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  hglc_req_if.sink       req_i,
  hglc_res_if.source     res_o
);

  phase_e                      phase_q, phase_d;
  logic [3:0]                  match_idx_q, match_idx_d;
  logic signed [DEPTH_W-1:0]   depth_q, depth_d;
  logic                        slash_pend_q, slash_pend_d;
  logic [1:0]                  dotdot_q, dotdot_d;
  logic [7:0]                  last_byte_q, last_byte_d;
  logic [PATH_LEN_W-1:0]       path_cnt_q, path_cnt_d;
  logic                        finished_q, finished_d;
  logic [BYTE_CNT_W-1:0]       byte_cnt_q, byte_cnt_d;

  logic                        out_valid_q;
  logic                        out_kind_q;
  logic [7:0]                  out_byte_q;
  logic [2:0]                  out_verdict_q;
  logic [PATH_LEN_W-1:0]       out_len_q;

  logic                        res_valid;
  kind_e                       res_kind;
  logic [7:0]                  res_byte;
  verdict_e                    res_verdict;
  logic [PATH_LEN_W-1:0]       res_len;

  logic                        in_fire;

  // Effective state for this beat, after a possible restart.
  phase_e                      ph;
  logic [3:0]                  mi;
  logic signed [DEPTH_W-1:0]   dep, dep_inc, dep_dec, dep_end;
  logic                        sp;
  logic [1:0]                  dd;
  logic [7:0]                  lpb;
  logic [PATH_LEN_W-1:0]       pc;
  logic                        fin;
  logic [BYTE_CNT_W-1:0]       bc;
  logic [7:0]                  b;

  assign in_fire     = req_i.valid && req_i.ready;
  assign req_i.ready = !out_valid_q || res_o.ready;

  always_comb begin
    b   = req_i.data_byte;
    ph  = req_i.first ? PH_METHOD : phase_q;
    mi  = req_i.first ? 4'd0 : match_idx_q;
    dep = req_i.first ? '0 : depth_q;
    sp  = req_i.first ? 1'b0 : slash_pend_q;
    dd  = req_i.first ? 2'd0 : dotdot_q;
    lpb = req_i.first ? 8'd0 : last_byte_q;
    pc  = req_i.first ? '0 : path_cnt_q;
    fin = req_i.first ? 1'b0 : finished_q;
    bc  = req_i.first ? '0 : byte_cnt_q;

    dep_inc = (dep == DEPTH_MAX) ? dep : dep + DEPTH_W'(1);
    dep_dec = (dep == DEPTH_MIN) ? dep : dep - DEPTH_W'(1);
    dep_end = sp ? dep_inc : dep;

    phase_d      = ph;
    match_idx_d  = mi;
    depth_d      = dep;
    slash_pend_d = sp;
    dotdot_d     = dd;
    last_byte_d  = lpb;
    path_cnt_d   = pc;
    finished_d   = fin;
    byte_cnt_d   = bc;

    res_valid   = 1'b0;
    res_kind    = KIND_VERDICT;
    res_byte    = 8'd0;
    res_verdict = VERDICT_ACCEPTED;
    res_len     = pc;

    if (!fin) begin
      if (bc == BYTE_CNT_W'(MAX_REQUEST)) begin
        // Request ran out of room before a verdict.
        res_valid  = 1'b1;
        finished_d = 1'b1;
        if (ph == PH_METHOD) begin
          res_verdict = VERDICT_BAD_METHOD;
        end else if (ph == PH_PRESLASH) begin
          res_verdict = VERDICT_NO_SLASH;
        end else begin
          res_verdict = VERDICT_BAD_VER;
        end
      end else begin
        byte_cnt_d = bc + BYTE_CNT_W'(1);
        unique case (ph)
          PH_METHOD: begin
            if (b != method_char(mi[1:0])) begin
              res_valid   = 1'b1;
              finished_d  = 1'b1;
              res_verdict = VERDICT_BAD_METHOD;
            end else if (mi == 4'd3) begin
              match_idx_d = 4'd0;
              phase_d     = PH_PRESLASH;
            end else begin
              match_idx_d = mi + 4'd1;
            end
          end
          PH_PRESLASH: begin
            if (b == CHAR_SLASH) begin
              last_byte_d  = b;
              slash_pend_d = 1'b1;
              dotdot_d     = 2'd0;
              phase_d      = PH_PATH;
            end else if (b != CHAR_SPACE) begin
              res_valid   = 1'b1;
              finished_d  = 1'b1;
              res_verdict = VERDICT_NO_SLASH;
            end
          end
          PH_PATH: begin
            if (b == CHAR_SPACE || b == CHAR_NEWLINE) begin
              // A slash whose "../" check is cut off counts as one level down.
              depth_d      = dep_end;
              slash_pend_d = 1'b0;
              dotdot_d     = 2'd0;
              if (lpb == CHAR_SLASH) begin
                res_valid   = 1'b1;
                finished_d  = 1'b1;
                res_verdict = VERDICT_TRAILING;
              end else if (dep_end <= DEPTH_W'(0)) begin
                res_valid   = 1'b1;
                finished_d  = 1'b1;
                res_verdict = VERDICT_ESCAPES;
              end else begin
                phase_d = PH_PREVER;
              end
            end else begin
              if (sp) begin
                if (b == dotdot_char(dd)) begin
                  if (dd == 2'd2) begin
                    depth_d      = dep_dec;
                    slash_pend_d = 1'b0;
                    dotdot_d     = 2'd0;
                  end else begin
                    dotdot_d = dd + 2'd1;
                  end
                end else begin
                  depth_d      = dep_inc;
                  slash_pend_d = 1'b0;
                  dotdot_d     = 2'd0;
                end
              end
              if (b == CHAR_SLASH) begin
                slash_pend_d = 1'b1;
                dotdot_d     = 2'd0;
              end
              last_byte_d = b;
              path_cnt_d  = (pc == PATH_LEN_MAX) ? pc : pc + PATH_LEN_W'(1);
              res_valid   = 1'b1;
              res_kind    = KIND_PATH;
              res_byte    = b;
              res_len     = path_cnt_d;
            end
          end
          PH_PREVER: begin
            if (b != CHAR_SPACE) begin
              // This byte already is the first version byte.
              phase_d = PH_VERSION;
              if (b != version_char(3'd0)) begin
                res_valid   = 1'b1;
                finished_d  = 1'b1;
                res_verdict = VERDICT_BAD_VER;
              end else begin
                match_idx_d = 4'd1;
              end
            end
          end
          PH_VERSION: begin
            if (b != version_char(mi[2:0])) begin
              res_valid   = 1'b1;
              finished_d  = 1'b1;
              res_verdict = VERDICT_BAD_VER;
            end else if (mi == 4'd7) begin
              match_idx_d = 4'd8;
              res_valid   = 1'b1;
              finished_d  = 1'b1;
              res_verdict = VERDICT_ACCEPTED;
            end else begin
              match_idx_d = mi + 4'd1;
            end
          end
          default: begin
            phase_d = PH_METHOD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_METHOD;
      match_idx_q  <= 4'd0;
      depth_q      <= '0;
      slash_pend_q <= 1'b0;
      dotdot_q     <= 2'd0;
      last_byte_q  <= 8'd0;
      path_cnt_q   <= '0;
      finished_q   <= 1'b0;
      byte_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q      <= phase_d;
        match_idx_q  <= match_idx_d;
        depth_q      <= depth_d;
        slash_pend_q <= slash_pend_d;
        dotdot_q     <= dotdot_d;
        last_byte_q  <= last_byte_d;
        path_cnt_q   <= path_cnt_d;
        finished_q   <= finished_d;
        byte_cnt_q   <= byte_cnt_d;
        out_valid_q  <= res_valid;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_kind_q    <= res_kind;
      out_byte_q    <= res_byte;
      out_verdict_q <= res_verdict;
      out_len_q     <= res_len;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.kind        = out_kind_q;
  assign res_o.path_byte   = out_byte_q;
  assign res_o.verdict     = out_verdict_q;
  assign res_o.path_length = out_len_q;

  // The version is only looked at once the path has left a positive depth.
  a_prever_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PREVER) |-> (depth_q > DEPTH_W'(0) && !slash_pend_q))
    else $error("version phase entered with non-positive depth");

  // Every path beat counts itself, so its length is never zero.
  a_path_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KIND_PATH) |-> (out_len_q != '0))
    else $error("path beat with zero length");

  // An ordinary path byte of a live request yields a path beat next cycle.
  a_path_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !req_i.first && !finished_q && phase_q == PH_PATH &&
     byte_cnt_q != BYTE_CNT_W'(MAX_REQUEST) &&
     req_i.data_byte != CHAR_SPACE && req_i.data_byte != CHAR_NEWLINE)
    |=> (out_valid_q && out_kind_q == KIND_PATH))
    else $error("path byte produced no path beat");

endmodule
